[design/flat_json_object_tokenizer_defines.svh]
// Assertion macros for the flat JSON object tokenizer.
`ifndef FLAT_JSON_OBJECT_TOKENIZER_DEFINES_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FJT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define FJT_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define FJT_ASSERT(label, clk, rst_n, prop)
`define FJT_ASSERT_NR(label, clk, prop)
`endif
`endif

[design/fjt_pkg.sv]
// ----------------------------------------------------------------------------
// fjt_pkg
// Types and codes shared by the flat JSON object tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package fjt_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } fjt_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  pair_index;
    logic [11:0] key_offset;
    logic [11:0] key_length;
    logic [11:0] value_offset;
    logic [12:0] value_length;
    logic [2:0]  value_type;
    logic [1:0]  status;
    logic        last_of_run;
  } fjt_out_t;

  // One byte's worth of results: up to two items.
  typedef struct packed {
    logic     two;
    fjt_out_t first;
    fjt_out_t second;
  } fjt_run_t;

  localparam logic       KIND_PAIR   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SYNTAX   = 2'd1;
  localparam logic [1:0] ST_PAIRS    = 2'd2;
  localparam logic [1:0] ST_LIMIT    = 2'd3;
  localparam logic [2:0] VT_STRING   = 3'd0;
  localparam logic [2:0] VT_OBJECT   = 3'd1;
  localparam logic [2:0] VT_BOOL     = 3'd2;
  localparam logic [2:0] VT_NULL     = 3'd3;
  localparam logic [2:0] VT_NUMBER   = 3'd4;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Expected literal character: sel 0 true, 1 false, 2 null.
  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] k);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      2'd0: case (k)
        3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
      endcase
      2'd1: case (k)
        3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e"; default: c = 8'h00;
      endcase
      2'd2: case (k)
        3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
      endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

[design/fjt_front.sv]
// ----------------------------------------------------------------------------
// fjt_front
// Per-byte parser: classifies each byte and produces its run of results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flat_json_object_tokenizer_defines.svh"
module fjt_front import fjt_pkg::*; #(
  parameter int MAX_PAIRS        = 16,
  parameter int MAX_BUFFER_BYTES = 4096,
  parameter int MAX_NEST_DEPTH   = 15
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire fjt_in_t  in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output fjt_run_t      q_run
);
  localparam int PW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int DW = $clog2(MAX_NEST_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_OPEN, PH_FIRST, PH_KEYSTART, PH_KEY, PH_COLON, PH_VALUE, PH_VSTR,
    PH_VOBJ, PH_VOBJSTR, PH_LIT, PH_SIGN, PH_NUM, PH_AFTER
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [11:0] kst_r, kst_nxt, ksz_r, ksz_nxt, vst_r, vst_nxt;
  logic [2:0]  typ_r, typ_nxt, lp_r, lp_nxt;
  logic [DW-1:0] dep_r, dep_nxt;
  logic        esc_r, esc_nxt, fin_r, fin_nxt;
  logic [1:0]  sel_r, sel_nxt;

  logic [7:0]  b;
  logic [11:0] pos12;
  logic        pair_en, stat_en;
  logic [12:0] pair_len;
  logic [1:0]  stat;
  fjt_out_t    pr, sr;
  logic        acc;
  logic        q_has;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign b        = in_data.data_byte;
  assign pos12    = pos_r[11:0];

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; cnt_nxt = cnt_r; kst_nxt = kst_r;
    ksz_nxt = ksz_r; vst_nxt = vst_r; typ_nxt = typ_r; lp_nxt = lp_r;
    dep_nxt = dep_r; esc_nxt = esc_r; fin_nxt = fin_r; sel_nxt = sel_r;
    pair_en = 1'b0; stat_en = 1'b0; pair_len = '0; stat = ST_OK;
    if (!fin_r) begin
      if (pos_r >= PW'(MAX_BUFFER_BYTES)) begin
        stat_en = 1'b1; stat = ST_LIMIT;
      end else begin
        pos_nxt = pos_r + 1'b1;
        case (phase_r)
          PH_OPEN: begin
            if (b == "{") phase_nxt = PH_FIRST;
            else if (!is_ws(b)) begin stat_en = 1'b1; stat = ST_SYNTAX; end
          end
          PH_FIRST, PH_KEYSTART: begin
            if (phase_r == PH_FIRST && b == "}") begin
              stat_en = 1'b1; stat = ST_OK;
            end else if (b == 8'h22) begin
              kst_nxt = pos12 + 12'd1; esc_nxt = 1'b0; phase_nxt = PH_KEY;
            end else if (!is_ws(b)) begin stat_en = 1'b1; stat = ST_SYNTAX; end
          end
          PH_KEY: begin
            if (esc_r) esc_nxt = 1'b0;
            else if (b == 8'h5C) esc_nxt = 1'b1;
            else if (b == 8'h22) begin
              ksz_nxt = pos12 - kst_r; phase_nxt = PH_COLON;
            end
          end
          PH_COLON: begin
            if (b == ":") phase_nxt = PH_VALUE;
            else if (!is_ws(b)) begin stat_en = 1'b1; stat = ST_SYNTAX; end
          end
          PH_VALUE: begin
            if (!is_ws(b)) begin
              vst_nxt = pos12; esc_nxt = 1'b0;
              if (b == 8'h22) begin
                vst_nxt = pos12 + 12'd1; typ_nxt = VT_STRING; phase_nxt = PH_VSTR;
              end else if (b == "{") begin
                typ_nxt = VT_OBJECT; dep_nxt = DW'(1); phase_nxt = PH_VOBJ;
              end else if (b == "t" || b == "f" || b == "n") begin
                sel_nxt = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
                typ_nxt = (b == "n") ? VT_NULL : VT_BOOL;
                lp_nxt = 3'd1; phase_nxt = PH_LIT;
              end else begin
                typ_nxt = VT_NUMBER;
                if (b == "-" || b == "+") phase_nxt = PH_SIGN;
                else if (is_digit(b)) phase_nxt = PH_NUM;
                else begin stat_en = 1'b1; stat = ST_SYNTAX; end
              end
            end
          end
          PH_VSTR: begin
            if (esc_r) esc_nxt = 1'b0;
            else if (b == 8'h5C) esc_nxt = 1'b1;
            else if (b == 8'h22) begin
              pair_en = 1'b1; pair_len = {1'b0, pos12 - vst_r};
            end
          end
          PH_VOBJ: begin
            if (b == 8'h22) begin
              esc_nxt = 1'b0; phase_nxt = PH_VOBJSTR;
            end else if (b == "{") begin
              if (dep_r >= DW'(MAX_NEST_DEPTH)) begin stat_en = 1'b1; stat = ST_LIMIT; end
              else dep_nxt = dep_r + 1'b1;
            end else if (b == "}") begin
              dep_nxt = dep_r - 1'b1;
              if (dep_r == DW'(1)) begin
                pair_en = 1'b1;
                pair_len = {1'b0, pos12} + 13'd1 - {1'b0, vst_r};
              end
            end
          end
          PH_VOBJSTR: begin
            if (esc_r) esc_nxt = 1'b0;
            else if (b == 8'h5C) esc_nxt = 1'b1;
            else if (b == 8'h22) phase_nxt = PH_VOBJ;
          end
          PH_LIT: begin
            if (b != lit_char(sel_r, lp_r)) begin
              stat_en = 1'b1; stat = ST_SYNTAX;
            end else begin
              lp_nxt = lp_r + 3'd1;
              if ((sel_r == 2'd1 && lp_r == 3'd4) || (sel_r != 2'd1 && lp_r == 3'd3)) begin
                pair_en = 1'b1; pair_len = (sel_r == 2'd1) ? 13'd5 : 13'd4;
              end
            end
          end
          PH_SIGN: begin
            if (is_digit(b)) phase_nxt = PH_NUM;
            else begin stat_en = 1'b1; stat = ST_SYNTAX; end
          end
          PH_NUM, PH_AFTER: begin
            if (phase_r == PH_NUM && !is_digit(b)) begin
              pair_en = 1'b1; pair_len = {1'b0, pos12 - vst_r};
            end
            if (phase_r == PH_AFTER || !is_digit(b)) begin
              phase_nxt = PH_AFTER;
              if (b == ",") begin
                if (pair_en ? (cnt_r + 1'b1 >= CW'(MAX_PAIRS)) : (cnt_r >= CW'(MAX_PAIRS))) begin
                  stat_en = 1'b1; stat = ST_PAIRS;
                end else phase_nxt = PH_KEYSTART;
              end else if (b == "}") begin
                stat_en = 1'b1; stat = ST_OK;
              end else if (!is_ws(b)) begin
                stat_en = 1'b1; stat = ST_SYNTAX;
              end
            end
          end
          default: begin stat_en = 1'b1; stat = ST_SYNTAX; end
        endcase
        if (pair_en) begin
          if (phase_r != PH_NUM) phase_nxt = PH_AFTER;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      if (!stat_en && in_data.end_of_buffer) begin
        stat_en = 1'b1; stat = ST_SYNTAX;
      end
      if (stat_en) fin_nxt = 1'b1;
    end
  end

  always_comb begin
    pr = '0;
    pr.result_kind  = KIND_PAIR;
    pr.pair_index   = 4'(cnt_r);
    pr.key_offset   = kst_r;
    pr.key_length   = ksz_r;
    pr.value_offset = vst_r;
    pr.value_length = pair_len;
    pr.value_type   = typ_r;
    pr.last_of_run  = !stat_en;
    sr = '0;
    sr.result_kind  = KIND_STATUS;
    sr.status       = stat;
    sr.last_of_run  = 1'b1;
    q_run.two    = pair_en && stat_en;
    q_run.first  = pair_en ? pr : sr;
    q_run.second = sr;
  end

  assign q_has  = pair_en || stat_en;
  assign q_push = acc && q_has;

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_data.end_of_buffer)) begin
      phase_r <= PH_OPEN; pos_r <= '0; cnt_r <= '0; kst_r <= '0; ksz_r <= '0;
      vst_r <= '0; typ_r <= '0; lp_r <= '0; dep_r <= '0; esc_r <= 1'b0;
      fin_r <= 1'b0; sel_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; cnt_r <= cnt_nxt; kst_r <= kst_nxt;
      ksz_r <= ksz_nxt; vst_r <= vst_nxt; typ_r <= typ_nxt; lp_r <= lp_nxt;
      dep_r <= dep_nxt; esc_r <= esc_nxt; fin_r <= fin_nxt; sel_r <= sel_nxt;
    end
  end

  `FJT_ASSERT(a_depth_bound, clk, rst_n, dep_r <= DW'(MAX_NEST_DEPTH))
  `FJT_ASSERT(a_pos_bound, clk, rst_n, pos_r <= PW'(MAX_BUFFER_BYTES))
  `FJT_ASSERT(a_fin_quiet, clk, rst_n, (fin_r && !in_data.end_of_buffer) |-> !q_has)
endmodule
`default_nettype wire

[design/fjt_back.sv]
// ----------------------------------------------------------------------------
// fjt_back
// Result queue and output sequencer; splits a two-item run over two transfers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flat_json_object_tokenizer_defines.svh"
module fjt_back import fjt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_push,
  input  wire fjt_run_t q_run,
  output logic          q_full,
  output logic          out_valid,
  input  wire logic     out_stall,
  output fjt_out_t      out_data
);
  fjt_run_t    mem [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  logic        half_r;
  logic        pop, take;
  fjt_run_t    head;

  assign head      = mem[rp_r];
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = half_r ? head.second : head.first;
  assign take      = out_valid && !out_stall;
  assign pop       = take && (half_r || !head.two);
  assign q_full    = cnt_r == 3'd4;

  always_ff @(posedge clk) begin
    if (q_push) mem[wp_r] <= q_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; half_r <= 1'b0;
    end else begin
      if (q_push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, q_push} - {2'b0, pop};
      if (pop) half_r <= 1'b0;
      else if (take) half_r <= 1'b1;
    end
  end

  `FJT_ASSERT(a_no_overflow, clk, rst_n, q_full |-> !q_push)
  `FJT_ASSERT(a_half_two, clk, rst_n, half_r |-> (head.two && out_valid))
  `FJT_ASSERT(a_count_bound, clk, rst_n, cnt_r <= 3'd4)
endmodule
`default_nettype wire

[design/flat_json_object_tokenizer.sv]
// Any results of a byte are queued as it is accepted. Throughput: one byte per
// cycle unless the queue is full; a byte with two results (a pair plus a
// status) takes two output transfers, absorbed by a four-entry queue.
// Reset: synchronous active-low rst_n clears parser state and empties the queue.
// The parser also rearms itself after every end_of_buffer byte.
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer
// Streaming tokenizer for one flat JSON object, reporting key/value pairs.
// ----------------------------------------------------------------------------
`default_nettype none
module flat_json_object_tokenizer import fjt_pkg::*; #(
  parameter int MAX_PAIRS        = 16,
  parameter int MAX_BUFFER_BYTES = 4096,
  parameter int MAX_NEST_DEPTH   = 15
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire fjt_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output fjt_out_t     out_data
);
  // Front parses a byte per transfer; back queues runs of results.
  logic     q_full, q_push;
  fjt_run_t q_run;

  fjt_front #(
    .MAX_PAIRS(MAX_PAIRS), .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
    .MAX_NEST_DEPTH(MAX_NEST_DEPTH)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_full, .q_push, .q_run
  );

  fjt_back u_back (
    .clk, .rst_n, .q_push, .q_run, .q_full, .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire
